// ===== sv/crc8_packet_deframer_core_macros.svh =====
// Assertion macros for the CRC-8 packet deframer.
// Included by the top level; depends on nothing else.
`ifndef CRC8_PACKET_DEFRAMER_CORE_MACROS_SVH
`define CRC8_PACKET_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define CDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== sv/cdf_pkg.sv =====
// Shared types, codes and the CRC-8 step for the packet deframer.
// Used by the controller, the datapath and the top level.
package cdf_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 64;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_MARKER  = 3'd0;
    localparam logic [2:0] REG_STORE_COMMAND = 3'd1;
    localparam logic [2:0] REG_FETCH_COMMAND = 3'd2;
    localparam logic [2:0] REG_STORE_LENGTH  = 3'd3;

    localparam logic [7:0] START_MARKER_RST  = 8'hBB;
    localparam logic [7:0] STORE_COMMAND_RST = 8'h02;
    localparam logic [7:0] FETCH_COMMAND_RST = 8'h03;
    localparam logic [5:0] STORE_LENGTH_RST  = 6'd12;

    // Result status codes.
    localparam logic [1:0] STAT_OTHER = 2'd0;
    localparam logic [1:0] STAT_STORE = 2'd1;
    localparam logic [1:0] STAT_FETCH = 2'd2;
    localparam logic [1:0] STAT_ERROR = 2'd3;

    typedef struct packed {
        logic take_byte;
        logic rd_clear;
        logic rd_en;
        logic rd_advance;
        logic load_payload;
        logic load_single;
    } cdf_cmd_t;

    typedef struct packed {
        logic at_crc;
        logic crc_ok;
        logic len_zero;
        logic out_free;
        logic rd_last;
    } cdf_stat_t;

    // One byte through CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/cdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cdf_ctrl.sv =====
// Controller state machine of the packet deframer.
// Depends on cdf_pkg for the command and status structs.
module cdf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cdf_pkg::cdf_stat_t  stat,
    output cdf_pkg::cdf_cmd_t   cmd
);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_LOAD   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_tready      = 1'b1;
                cmd.take_byte = s_tvalid;
                if (s_tvalid && stat.at_crc) begin
                    cmd.rd_clear = 1'b1;
                    // A bad CRC or an empty payload reports as one result.
                    if (!stat.crc_ok || stat.len_zero) begin
                        state_next = ST_SINGLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SINGLE: begin
                if (stat.out_free) begin
                    cmd.load_single = 1'b1;
                    state_next      = ST_RUN;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (stat.out_free) begin
                    cmd.load_payload = 1'b1;
                    if (stat.rd_last) begin
                        state_next = ST_RUN;
                    end else begin
                        cmd.rd_advance = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/cdf_datapath.sv =====
// Datapath of the packet deframer: config registers, frame tracking, CRC,
// payload buffer and output register. Depends on cdf_pkg and cdf_ram.
module cdf_datapath #(
    parameter int BUFFER_BYTES = cdf_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic [7:0]         rx_byte,
    input  cdf_pkg::cdf_cmd_t  cmd,
    output cdf_pkg::cdf_stat_t stat,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [31:0]        m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    logic [7:0]    start_marker_reg;
    logic [7:0]    store_command_reg;
    logic [7:0]    fetch_command_reg;
    logic [5:0]    store_length_reg;

    logic [PW-1:0] position_reg, position_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    length_reg, length_next;
    logic [7:0]    crc_reg, crc_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] rd_idx_reg;

    logic [PW-1:0] pay_idx;
    logic [PW-1:0] pos_inc;
    logic [7:0]    crc_step;
    logic          in_payload;
    logic          wr_en;
    logic [7:0]    rd_data;
    logic [1:0]    class_code;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [7:0]    out_command_reg;
    logic [5:0]    out_length_reg;
    logic          out_has_reg;
    logic [5:0]    out_index_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg  <= cdf_pkg::START_MARKER_RST;
            store_command_reg <= cdf_pkg::STORE_COMMAND_RST;
            fetch_command_reg <= cdf_pkg::FETCH_COMMAND_RST;
            store_length_reg  <= cdf_pkg::STORE_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cdf_pkg::REG_START_MARKER:  start_marker_reg  <= cfg_wdata;
                cdf_pkg::REG_STORE_COMMAND: store_command_reg <= cfg_wdata;
                cdf_pkg::REG_FETCH_COMMAND: fetch_command_reg <= cfg_wdata;
                cdf_pkg::REG_STORE_LENGTH:  store_length_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign pay_idx    = position_reg - PW'(3);
    assign pos_inc    = position_reg + PW'(1);
    assign in_payload = (position_reg >= PW'(3));
    assign crc_step   = cdf_pkg::crc8_feed(crc_reg, rx_byte);

    assign stat.at_crc   = in_payload && (CW'(pay_idx) >= CW'(length_reg));
    assign stat.crc_ok   = (crc_reg == rx_byte);
    assign stat.len_zero = (length_reg == 8'd0);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.rd_last  = ((CW'(rd_idx_reg) + CW'(1)) == CW'(length_reg));

    // A store command counts only at the configured length.
    always_comb begin
        if (command_reg == store_command_reg) begin
            class_code = (length_reg == {2'b00, store_length_reg}) ?
                         cdf_pkg::STAT_STORE : cdf_pkg::STAT_OTHER;
        end else if (command_reg == fetch_command_reg) begin
            class_code = cdf_pkg::STAT_FETCH;
        end else begin
            class_code = cdf_pkg::STAT_OTHER;
        end
    end

    always_comb begin
        position_next = position_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        crc_next      = crc_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        if (cmd.take_byte) begin
            priority if (position_reg == '0) begin
                if (rx_byte == start_marker_reg) begin
                    crc_next      = cdf_pkg::crc8_feed(8'd0, rx_byte);
                    position_next = pos_inc;
                end
            end else if (position_reg == PW'(1)) begin
                command_next  = rx_byte;
                crc_next      = crc_step;
                position_next = pos_inc;
            end else if (position_reg == PW'(2)) begin
                length_next   = rx_byte;
                crc_next      = crc_step;
                position_next = pos_inc;
            end else if (stat.at_crc) begin
                position_next = '0;
                status_next   = stat.crc_ok ? class_code : cdf_pkg::STAT_ERROR;
            end else begin
                wr_en         = 1'b1;
                crc_next      = crc_step;
                position_next = pos_inc;
            end
            // A frame that fills the buffer without finishing is dropped.
            if (position_next >= PW'(BUFFER_BYTES)) begin
                position_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            command_reg  <= '0;
            length_reg   <= '0;
            crc_reg      <= '0;
            status_reg   <= cdf_pkg::STAT_OTHER;
            rd_idx_reg   <= '0;
        end else begin
            position_reg <= position_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            crc_reg      <= crc_next;
            status_reg   <= status_next;
            if (cmd.rd_clear) begin
                rd_idx_reg <= '0;
            end else if (cmd.rd_advance) begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    cdf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pay_idx[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_payload || cmd.load_single) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_payload || cmd.load_single) begin
            out_status_reg  <= status_reg;
            out_command_reg <= command_reg;
            out_length_reg  <= length_reg[5:0];
            out_has_reg     <= cmd.load_payload;
            out_index_reg   <= cmd.load_payload ? 6'(rd_idx_reg) : 6'd0;
            out_byte_reg    <= cmd.load_payload ? rd_data : 8'd0;
            out_last_reg    <= cmd.load_single || stat.rd_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_byte_reg, out_index_reg, out_length_reg, out_command_reg};
    assign m_tuser  = {out_has_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/crc8_packet_deframer_core.sv =====
// CRC-8 packet deframer, top level.
// The input channel (s_) carries one received byte per word in s_tdata[7:0].
// Idle bytes are skipped until the start marker; a frame is start, command,
// length, payload and a CRC-8 byte (poly 0x07, init 0) over all but the CRC.
// Each good frame yields one word per payload byte on the m_ channel, or a
// single word when the payload is empty; a CRC mismatch yields one error word.
// m_tlast marks the final word of a frame's run.
// Bytes are taken one per cycle while no run is being sent. A single result
// (error or empty payload) is loaded into the output register from the single
// state that follows its CRC byte, once that register is free. A payload run
// reads each byte from the payload buffer, whose read port is registered, and
// then loads it into the output register; the next byte is read only after that load.
// Input is held off while a single result or a payload run waits to be loaded,
// and so also for as long as the receiver stalls.
// A stalled receiver holds the output register and the run pauses with it.
// Frames that reach the buffer size without a CRC byte are dropped silently.
// Reset (aresetn low, synchronous) returns to hunting, clears the output and
// restores the register defaults; configuration writes take effect at once.
module crc8_packet_deframer_core #(
    parameter int BUFFER_BYTES = cdf_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] command, [13:8] frame_length, [19:14] byte_index, [27:20] payload_byte
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,   // [1:0] status, [2] has_payload
    output logic        m_tlast
);

    `include "crc8_packet_deframer_core_macros.svh"

    cdf_pkg::cdf_cmd_t  cmd;
    cdf_pkg::cdf_stat_t stat;

    cdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdf_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // While a run is still being sent, no input byte is taken.
    `CDF_ASSERT_NOW(a_run_blocks_input, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
    // The output register is loaded only when it is empty or being drained.
    `CDF_ASSERT_NOW(a_load_when_free, aclk, aresetn,
        cmd.load_payload || cmd.load_single, !m_tvalid || m_tready)
    // A word without payload always closes its frame's run.
    `CDF_ASSERT_NOW(a_empty_is_last, aclk, aresetn, m_tvalid && !m_tuser[2], m_tlast)
    // An error word never carries payload.
    `CDF_ASSERT_NOW(a_error_no_payload, aclk, aresetn,
        m_tvalid && (m_tuser[1:0] == cdf_pkg::STAT_ERROR), !m_tuser[2])
    // Once a CRC byte is taken, input is held off on the next cycle.
    `CDF_ASSERT_NEXT(a_crc_starts_run, aclk, aresetn,
        s_tvalid && s_tready && stat.at_crc, !s_tready)

endmodule

// ===== sim/crc8_packet_deframer_checker.sv =====
// Scoreboard for the CRC-8 packet deframer: watches the config port and both streams,
// predicts every output word from the accepted input bytes and compares them in order.
// Depends on cdf_pkg for register indexes, status codes and reset defaults.
module crc8_packet_deframer_checker
    import cdf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [5:0] frame_length;
        logic       has_payload;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } deframed_word_t;

    deframed_word_t expected_words[$];

    // Mirror of the configuration registers.
    logic [7:0] start_marker_r;
    logic [7:0] store_cmd_r;
    logic [7:0] fetch_cmd_r;
    logic [5:0] store_len_r;

    // Mirror of the frame tracking state.
    int unsigned frame_pos;
    logic [7:0]  len_seen;
    logic [7:0]  cmd_seen;
    logic [7:0]  crc_acc;
    logic [7:0]  payload_buf [BUFFER_BYTES];

    int fail_total = 0;

    // Bit-serial CRC-8, message bits taken MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic string word_text(input deframed_word_t w);
        return $sformatf("status=%0d cmd=%02h len=%0d has=%0b idx=%0d byte=%02h last=%0b",
                         w.status, w.command, w.frame_length, w.has_payload,
                         w.byte_index, w.payload_byte, w.last);
    endfunction

    task automatic push_word(input logic [1:0] status, input logic has, input int idx,
                             input logic [7:0] data, input logic last);
        deframed_word_t w;
        w.status       = status;
        w.command      = cmd_seen;
        w.frame_length = len_seen[5:0];
        w.has_payload  = has;
        w.byte_index   = idx[5:0];
        w.payload_byte = data;
        w.last         = last;
        expected_words.push_back(w);
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [1:0]  st;
        int unsigned idx;
        if (frame_pos == 0) begin
            if (b == start_marker_r) begin
                crc_acc   = crc8_next(8'h00, b);
                frame_pos = 1;
            end
        end else if (frame_pos == 1) begin
            cmd_seen  = b;
            crc_acc   = crc8_next(crc_acc, b);
            frame_pos = 2;
        end else if (frame_pos == 2) begin
            len_seen  = b;
            crc_acc   = crc8_next(crc_acc, b);
            frame_pos = 3;
        end else begin
            idx = frame_pos - 3;
            if (idx < len_seen) begin
                if (idx < BUFFER_BYTES) begin
                    payload_buf[idx] = b;
                end
                crc_acc   = crc8_next(crc_acc, b);
                frame_pos = frame_pos + 1;
            end else begin
                // This byte is the CRC, so the frame is complete.
                frame_pos = 0;
                if (crc_acc != b) begin
                    push_word(STAT_ERROR, 1'b0, 0, 8'h00, 1'b1);
                end else begin
                    // A store command with the wrong length is not a fetch either.
                    if (cmd_seen == store_cmd_r) begin
                        st = (len_seen == {2'b00, store_len_r}) ? STAT_STORE : STAT_OTHER;
                    end else if (cmd_seen == fetch_cmd_r) begin
                        st = STAT_FETCH;
                    end else begin
                        st = STAT_OTHER;
                    end
                    if (len_seen == 0) begin
                        push_word(st, 1'b0, 0, 8'h00, 1'b1);
                    end else begin
                        for (int i = 0; i < len_seen && i < BUFFER_BYTES; i++) begin
                            push_word(st, 1'b1, i, payload_buf[i], (i + 1 == len_seen));
                        end
                    end
                end
            end
        end
        if (frame_pos >= BUFFER_BYTES) begin
            frame_pos = 0;
        end
    endtask

    always @(posedge aclk) begin : watch
        deframed_word_t got;
        deframed_word_t want;
        if (!aresetn) begin
            start_marker_r = START_MARKER_RST;
            store_cmd_r    = STORE_COMMAND_RST;
            fetch_cmd_r    = FETCH_COMMAND_RST;
            store_len_r    = STORE_LENGTH_RST;
            frame_pos      = 0;
            len_seen       = 8'h00;
            cmd_seen       = 8'h00;
            crc_acc        = 8'h00;
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status       = m_tuser[1:0];
                got.has_payload  = m_tuser[2];
                got.command      = m_tdata[7:0];
                got.frame_length = m_tdata[13:8];
                got.byte_index   = m_tdata[19:14];
                got.payload_byte = m_tdata[27:20];
                got.last         = m_tlast;
                if (expected_words.size() == 0) begin
                    if (fail_total < REPORT_LIMIT) begin
                        $display("%0t: unexpected word: %s", $realtime, word_text(got));
                    end
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (fail_total < REPORT_LIMIT) begin
                            $display("%0t: word mismatch", $realtime);
                            $display("    expected %s", word_text(want));
                            $display("    actual   %s", word_text(got));
                        end
                        fail_total++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_MARKER:  start_marker_r = cfg_wdata;
                    REG_STORE_COMMAND: store_cmd_r    = cfg_wdata;
                    REG_FETCH_COMMAND: fetch_cmd_r    = cfg_wdata;
                    REG_STORE_LENGTH:  store_len_r    = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata);
            end
        end
        pending_count <= expected_words.size();
        fail_count    <= fail_total;
    end

endmodule

// ===== sim/tb_crc8_packet_deframer_core.sv =====
// Top-level testbench for the CRC-8 packet deframer: clock, reset, config writes,
// directed and random frame traffic with random stalls on both streams.
// Depends on cdf_pkg, the deframer RTL and crc8_packet_deframer_checker.
module tb_crc8_packet_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cdf_pkg::*;

    localparam int BUFFER_BYTES = BUFFER_BYTES_DEFAULT;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 10;
    localparam int CYCLE_LIMIT  = 400000;
    // No register lives at this index; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_count;

    logic [7:0] start_marker_now = START_MARKER_RST;
    logic [7:0] store_cmd_now    = STORE_COMMAND_RST;
    logic [7:0] fetch_cmd_now    = FETCH_COMMAND_RST;
    logic [5:0] store_len_now    = STORE_LENGTH_RST;
    bit         tx_steady        = 1'b0;
    bit         rx_steady        = 1'b0;
    int         bytes_sent       = 0;
    int         cycle_count      = 0;

    crc8_packet_deframer_core #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (.*);

    crc8_packet_deframer_checker #(.BUFFER_BYTES(BUFFER_BYTES)) deframe_check (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_cycle(input logic [2:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_registers(input logic [7:0] start, input logic [7:0] store,
                                 input logic [7:0] fetch, input logic [7:0] slen);
        write_cycle(REG_UNUSED, 8'($urandom));
        write_cycle(REG_START_MARKER, start);
        write_cycle(REG_STORE_COMMAND, store);
        write_cycle(REG_FETCH_COMMAND, fetch);
        write_cycle(REG_STORE_LENGTH, slen);
        cfg_wr_en <= 1'b0;
        start_marker_now = start;
        store_cmd_now    = store;
        fetch_cmd_now    = fetch;
        store_len_now    = slen[5:0];
    endtask

    // Leaves s_tvalid high after the handshake so back-to-back words need no re-raise.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0) begin
            tx_steady = !tx_steady;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Lengths above what fits in the buffer get no CRC byte: the frame runs out and is dropped.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        int         n;
        crc = crc8_feed(8'h00, start_marker_now);
        send_byte(start_marker_now);
        crc = crc8_feed(crc, cmd);
        send_byte(cmd);
        crc = crc8_feed(crc, len);
        send_byte(len);
        n = (len > BUFFER_BYTES - 4) ? BUFFER_BYTES - 3 : len;
        for (int i = 0; i < n; i++) begin
            b   = ($urandom_range(0, 3) == 0) ? start_marker_now : 8'($urandom);
            crc = crc8_feed(crc, b);
            send_byte(b);
        end
        if (len <= BUFFER_BYTES - 4) begin
            send_byte(bad_crc ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc);
        end
    endtask

    task automatic random_traffic(input int budget);
        int         first;
        int         pick;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] b;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                repeat ($urandom_range(1, 3)) begin
                    b = 8'($urandom);
                    send_byte((b == start_marker_now) ? ~b : b);
                end
            end else if (pick < 10) begin
                // Truncated frame; the following bytes get absorbed into it.
                send_byte(start_marker_now);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end else if (pick < 13) begin
                send_frame(8'($urandom), 8'($urandom_range(BUFFER_BYTES - 3, 255)), 1'b0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       cmd = store_cmd_now;
                    1:       cmd = fetch_cmd_now;
                    default: cmd = 8'($urandom);
                endcase
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    len = {2'b00, store_len_now};
                end else if (pick == 1) begin
                    len = 8'(BUFFER_BYTES - 4);
                end else if (pick < 5) begin
                    len = 8'h00;
                end else begin
                    len = 8'($urandom_range(1, 8));
                end
                send_frame(cmd, len, $urandom_range(0, 6) == 0);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0) begin
                rx_steady = !rx_steady;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: idle bytes, fetch, a bad CRC, start byte as data, buffer edges.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FETCH_COMMAND_RST, 8'h00, 1'b0);
        send_frame(8'hFF, 8'h00, 1'b1);
        send_frame(START_MARKER_RST, 8'h02, 1'b0);
        send_frame(8'h00, 8'(BUFFER_BYTES - 4), 1'b0);
        send_frame(8'h5A, 8'(BUFFER_BYTES - 3), 1'b0);
        s_tvalid <= 1'b0;
        wait_drain();

        // Low extremes, with store and fetch sharing one code.
        set_registers(8'h00, 8'hFF, 8'hFF, 8'h00);
        send_frame(8'hFF, 8'h00, 1'b0);
        send_frame(8'hFF, 8'h03, 1'b0);
        s_tvalid <= 1'b0;
        wait_drain();

        set_registers(8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(0, BUFFER_BYTES - 4)));
        random_traffic(PHASE_BYTES);
        wait_drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
